@@ src/gtp_pkg.sv @@
// Shared types, constants and the CORDIC step for the go-to-point drive controller.
// No dependencies; imported by go_to_point_drive_controller_core.
package gtp_pkg;

    // Register indexes on the configuration port
    localparam logic [7:0] REG_GAIN_LINEAR      = 8'd0;
    localparam logic [7:0] REG_GAIN_HEADING     = 8'd1;
    localparam logic [7:0] REG_GAIN_FINAL_ANGLE = 8'd2;
    localparam logic [7:0] REG_SPEED_LIMIT      = 8'd3;

    // Angle constants
    localparam logic signed [17:0] PI_Q12      = 18'sd12868;
    localparam logic signed [17:0] TWO_PI_Q12  = 18'sd25736;
    localparam logic signed [17:0] HALF_PI_Q12 = 18'sd6434;
    localparam logic signed [19:0] PI_Q16      = 20'sd205887;

    localparam int CORDIC_STEPS = 16;
    localparam int SQRT_STEPS   = 25;
    localparam int RW           = 51;   // square root remainder / root width
    localparam int CW           = 48;   // CORDIC x / y width

    // arctan(2^-i) in Q.16
    localparam logic signed [19:0] ATAN_Q16 [CORDIC_STEPS] = '{
        20'sd51472, 20'sd30385, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
        20'sd1024,  20'sd512,   20'sd256,   20'sd128,  20'sd64,   20'sd32,
        20'sd16,    20'sd8,     20'sd4,     20'sd2
    };

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [19:0]   z;
    } cordic_t;

    // Per-item side data travelling alongside the square root stages
    typedef struct packed {
        logic signed [16:0] dth;    // target heading minus current heading
        logic signed [15:0] ch;     // current heading
        logic               zero;   // zero offset vector
        logic signed [17:0] he;     // heading error, later the steering operand
        logic               rev;    // target lies behind: drive in reverse
    } side_t;

    // One vectoring rotation
    function automatic cordic_t cordic_step(input cordic_t c, input logic [3:0] i);
        cordic_t              r;
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        xs = c.x >>> i;
        ys = c.y >>> i;
        if (c.y > 0)
        begin
            r.x = c.x + ys;
            r.y = c.y - xs;
            r.z = c.z + ATAN_Q16[i];
        end
        else
        begin
            r.x = c.x - ys;
            r.y = c.y + xs;
            r.z = c.z - ATAN_Q16[i];
        end
        return r;
    endfunction

endpackage

@@ src/go_to_point_drive_controller_core.sv @@
// Go-to-point drive controller: pipelined distance, bearing and steering datapath.
// Depends on gtp_pkg (types, angle constants, CORDIC step).
//
// Use:
//   The input channel (in_valid / in_stall) takes one word per cycle while in_stall
//   is low, holding the current pose and the target pose. The output channel
//   (out_valid / out_stall) returns one word per input word: linear_speed (Q8.8) and
//   angular_speed (Q4.12). The cfg port (cfg_we, cfg_index, cfg_data) writes the
//   four gain / limit registers; write only while no word is in flight.
// Pipeline: 32 register stages, set by the 25-stage bit-per-stage square root
//   (three entry stages, 25 root stages, three output arithmetic stages, then the
//   output register).
// Throughput: one word per cycle while in_stall is low; CORDIC rotations run beside the root stages.
// Reset: all valid bits clear, registers return to their defaults
//   (gain_linear 0.5, gain_heading 0.65, gain_final_angle 0.65, limit 15 cm/s).
// Stall: the output register is backed by a one-word skid stage. When the
//   receiver stalls with a word waiting, the next word parks in the skid stage;
//   only then does in_stall rise and the whole pipeline hold. Nothing is lost
//   or repeated.
module go_to_point_drive_controller_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [23:0]  cur_x,
    input  logic signed [23:0]  cur_y,
    input  logic signed [15:0]  cur_heading,
    input  logic signed [23:0]  target_x,
    input  logic signed [23:0]  target_y,
    input  logic signed [15:0]  target_heading,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [15:0]  linear_speed,
    output logic signed [15:0]  angular_speed
);
    import gtp_pkg::*;

    localparam int ANG_STAGE  = CORDIC_STEPS - 1;
    localparam int WRAP_STAGE = CORDIC_STEPS;
    localparam int REV_STAGE  = CORDIC_STEPS + 1;

    // configuration registers
    logic [15:0] gain_linear_reg;
    logic [15:0] gain_heading_reg;
    logic [15:0] gain_final_reg;
    logic [14:0] speed_limit_reg;

    logic en;

    // stage A
    logic               va_reg;
    logic signed [24:0] dx_a_reg;
    logic signed [24:0] dy_a_reg;
    side_t              side_a_reg;

    // stage B
    logic               vb_reg;
    logic [49:0]        sqx_b_reg;
    logic [49:0]        sqy_b_reg;
    cordic_t            crd_b_reg;
    side_t              side_b_reg;

    // stage C
    logic               vc_reg;
    logic [RW-1:0]      v_c_reg;
    cordic_t            crd_c_reg;
    side_t              side_c_reg;

    // root stages
    logic               sv_reg   [SQRT_STEPS];
    logic [RW-1:0]      sqv_reg  [SQRT_STEPS];
    logic [RW-1:0]      sqr_reg  [SQRT_STEPS];
    side_t              side_reg [SQRT_STEPS];
    cordic_t            crd_reg  [CORDIC_STEPS-1];

    // stage D
    logic               vd_reg;
    logic [40:0]        lin_d_reg;
    logic signed [34:0] head_d_reg;
    logic signed [34:0] fin_d_reg;
    logic [8:0]         w_d_reg;
    logic               rev_d_reg;

    // stage E
    logic               ve_reg;
    logic signed [15:0] lin_e_reg;
    logic signed [44:0] hw_e_reg;
    logic signed [44:0] fw_e_reg;

    // stage F
    logic               vf_reg;
    logic signed [15:0] lin_f_reg;
    logic signed [15:0] ang_f_reg;

    // output register and skid stage
    logic               out_valid_reg;
    logic signed [15:0] out_lin_reg;
    logic signed [15:0] out_ang_reg;
    logic               skid_valid_reg;
    logic signed [15:0] skid_lin_reg;
    logic signed [15:0] skid_ang_reg;

    // write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_linear_reg  <= 16'd8192;
            gain_heading_reg <= 16'd10650;
            gain_final_reg   <= 16'd10650;
            speed_limit_reg  <= 15'd3840;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GAIN_LINEAR:      gain_linear_reg  <= cfg_data;
                REG_GAIN_HEADING:     gain_heading_reg <= cfg_data;
                REG_GAIN_FINAL_ANGLE: gain_final_reg   <= cfg_data;
                REG_SPEED_LIMIT:      speed_limit_reg  <= cfg_data[14:0];
                default:              ;
            endcase
        end
    end

    // advance the pipeline unless the skid stage is occupied
    assign en       = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    // stage A: offsets and heading difference
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else if (en)
            va_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_a_reg        <= 25'(cur_x) - 25'(target_x);
            dy_a_reg        <= 25'(target_y) - 25'(cur_y);
            side_a_reg.dth  <= 17'(target_heading) - 17'(cur_heading);
            side_a_reg.ch   <= cur_heading;
            side_a_reg.zero <= (cur_x == target_x) && (cur_y == target_y);
            side_a_reg.he   <= '0;
            side_a_reg.rev  <= 1'b0;
        end
    end

    // stage B: squares and CORDIC pre-rotation into the right half plane
    logic signed [CW-1:0] xi_b;
    logic signed [CW-1:0] yi_b;
    logic signed [49:0]   px_b;
    logic signed [49:0]   py_b;

    assign xi_b = {{(CW-45){dy_a_reg[24]}}, dy_a_reg, 20'd0};
    assign yi_b = {{(CW-45){dx_a_reg[24]}}, dx_a_reg, 20'd0};
    assign px_b = dx_a_reg * dx_a_reg;
    assign py_b = dy_a_reg * dy_a_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vb_reg <= 1'b0;
        else if (en)
            vb_reg <= va_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_b_reg <= $unsigned(px_b);
            sqy_b_reg <= $unsigned(py_b);
            if (dy_a_reg < 0)
            begin
                crd_b_reg.x <= -xi_b;
                crd_b_reg.y <= -yi_b;
                crd_b_reg.z <= (dx_a_reg >= 0) ? PI_Q16 : -PI_Q16;
            end
            else
            begin
                crd_b_reg.x <= xi_b;
                crd_b_reg.y <= yi_b;
                crd_b_reg.z <= '0;
            end
            side_b_reg <= side_a_reg;
        end
    end

    // stage C: sum of squares and first rotation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vc_reg <= 1'b0;
        else if (en)
            vc_reg <= vb_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_c_reg    <= RW'(sqx_b_reg) + RW'(sqy_b_reg);
            crd_c_reg  <= cordic_step(crd_b_reg, 4'd0);
            side_c_reg <= side_b_reg;
        end
    end

    // root stages: one result bit each; rotations and heading error alongside
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sq
        localparam int BITPOS = SQRT_STEPS - 1 - k;
        logic          vin;
        logic [RW-1:0] v_in;
        logic [RW-1:0] r_in;
        side_t         s_in;
        side_t         s_next;
        logic [RW-1:0] bval;
        logic [RW-1:0] trial;

        if (k == 0)
        begin : g_first
            assign vin  = vc_reg;
            assign v_in = v_c_reg;
            assign r_in = '0;
            assign s_in = side_c_reg;
        end
        else
        begin : g_rest
            assign vin  = sv_reg[k-1];
            assign v_in = sqv_reg[k-1];
            assign r_in = sqr_reg[k-1];
            assign s_in = side_reg[k-1];
        end

        assign bval  = RW'(1) << (2 * BITPOS);
        assign trial = r_in + bval;

        // rotations 1 to 15
        if (k < CORDIC_STEPS - 1)
        begin : g_crd
            cordic_t c_in;
            if (k == 0)
            begin : g_c0
                assign c_in = crd_c_reg;
            end
            else
            begin : g_cn
                assign c_in = crd_reg[k-1];
            end
            always_ff @(posedge clk)
            begin
                if (en)
                    crd_reg[k] <= cordic_step(c_in, 4'(k + 1));
            end
        end

        // round the angle, form heading error, wrap, pick steering operand
        if (k == ANG_STAGE)
        begin : g_ang
            logic signed [19:0] zr;
            assign zr = (crd_reg[k-1].z + 20'sd8) >>> 4;
            always_comb
            begin
                s_next = s_in;
                if (s_in.zero)
                    s_next.he = -18'(s_in.ch);
                else
                    s_next.he = 18'(zr) - 18'(s_in.ch);
            end
        end
        else if (k == WRAP_STAGE)
        begin : g_wrap
            logic signed [17:0] h1;
            always_comb
            begin
                s_next = s_in;
                h1     = s_in.he;
                if (h1 > PI_Q12)
                    h1 = h1 - TWO_PI_Q12;
                if (h1 < -PI_Q12)
                    h1 = h1 + TWO_PI_Q12;
                s_next.he = h1;
            end
        end
        else if (k == REV_STAGE)
        begin : g_rev
            logic signed [17:0] ahe;
            assign ahe = (s_in.he < 0) ? -s_in.he : s_in.he;
            always_comb
            begin
                s_next = s_in;
                if (ahe > HALF_PI_Q12)
                begin
                    s_next.rev = 1'b1;
                    s_next.he  = PI_Q12 - ahe;
                end
            end
        end
        else
        begin : g_pass
            assign s_next = s_in;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sv_reg[k] <= 1'b0;
            else if (en)
                sv_reg[k] <= vin;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (v_in >= trial)
                begin
                    sqv_reg[k] <= v_in - trial;
                    sqr_reg[k] <= (r_in >> 1) + bval;
                end
                else
                begin
                    sqv_reg[k] <= v_in;
                    sqr_reg[k] <= r_in >> 1;
                end
                side_reg[k] <= s_next;
            end
        end
    end

    // stage D: gain products and blend weight
    logic [24:0]  dist_d;
    logic [10:0]  wraw_d;
    side_t        side_d;

    assign dist_d = sqr_reg[SQRT_STEPS-1][24:0];
    assign side_d = side_reg[SQRT_STEPS-1];
    assign wraw_d = 11'd1280 - {dist_d[9:0], 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vd_reg <= 1'b0;
        else if (en)
            vd_reg <= sv_reg[SQRT_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lin_d_reg  <= gain_linear_reg * dist_d;
            head_d_reg <= $signed({1'b0, gain_heading_reg}) * side_d.he;
            fin_d_reg  <= 35'($signed({1'b0, gain_final_reg}) * side_d.dth);
            if (dist_d >= 25'd640)
                w_d_reg <= '0;
            else if (wraw_d > 11'd256)
                w_d_reg <= 9'd256;
            else
                w_d_reg <= wraw_d[8:0];
            rev_d_reg  <= side_d.rev;
        end
    end

    // stage E: clamp speed, weight the two turning terms
    logic [27:0] lq_e;
    logic [15:0] lc_e;

    assign lq_e = 28'((42'(lin_d_reg) + 42'd8192) >> 14);
    assign lc_e = (lq_e > 28'(speed_limit_reg)) ? 16'(speed_limit_reg) : lq_e[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ve_reg <= 1'b0;
        else if (en)
            ve_reg <= vd_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lin_e_reg <= rev_d_reg ? -$signed(lc_e) : $signed(lc_e);
            hw_e_reg  <= head_d_reg * $signed({1'b0, 9'd256 - w_d_reg});
            fw_e_reg  <= fin_d_reg * $signed({1'b0, w_d_reg});
        end
    end

    // stage F: blend, round and saturate
    logic signed [45:0] sum_f;
    logic signed [23:0] sh_f;

    assign sum_f = 46'(hw_e_reg) + 46'(fw_e_reg) + 46'sd2097152;
    assign sh_f  = 24'(sum_f >>> 22);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vf_reg <= 1'b0;
        else if (en)
            vf_reg <= ve_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lin_f_reg <= lin_e_reg;
            if (sh_f > 24'sd32767)
                ang_f_reg <= 16'sh7fff;
            else if (sh_f < -24'sd32768)
                ang_f_reg <= 16'sh8000;
            else
                ang_f_reg <= sh_f[15:0];
        end
    end

    // output register with skid stage
    logic take;
    logic push;

    assign take = out_valid_reg && !out_stall;
    assign push = en && vf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (out_valid_reg && !take)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (take)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_lin_reg <= skid_lin_reg;
                out_ang_reg <= skid_ang_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !take)
            begin
                skid_lin_reg <= lin_f_reg;
                skid_ang_reg <= ang_f_reg;
            end
            else
            begin
                out_lin_reg <= lin_f_reg;
                out_ang_reg <= ang_f_reg;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign linear_speed  = out_lin_reg;
    assign angular_speed = out_ang_reg;

`ifndef SYNTH
    // skid stage only fills behind a waiting output word
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word without output word");

    // a held pipeline keeps its valid bits
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(va_reg) && $stable(vf_reg))
        else $error("pipeline moved while held");

    // blend weight stays within one
    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        vd_reg |-> w_d_reg <= 9'd256)
        else $error("blend weight out of range");

    // reverse drive never gives a forward speed
    a_reverse_sign: assert property (@(posedge clk) disable iff (!rst_n)
        en && vd_reg && rev_d_reg |=> lin_e_reg <= 16'sd0)
        else $error("reverse word with forward speed");
`endif

endmodule
